>>> sv/crc8wf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8wf_pkg
// Shared types, constants and the CRC-8 byte update for the word framer.
// ----------------------------------------------------------------------------
package crc8wf_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	localparam logic [1:0] VALUE_WORDS_RESET = 2'd2;

	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_TX    = 1'b1;

	localparam logic MODE_RX = 1'b0;
	localparam logic MODE_TX = 1'b1;

	typedef enum logic [2:0] {
		BEAT_CMD_HI = 3'd0,
		BEAT_CMD_LO = 3'd1,
		BEAT_ARG_HI = 3'd2,
		BEAT_ARG_LO = 3'd3,
		BEAT_CRC    = 3'd4
	} beat_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] value;
		logic        crc_ok;
	} rx_res_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       done;
	} tx_res_t;

	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> sv/crc8wf_rx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8wf_rx
// Receive framing: tracks byte position, word count, running CRC and the
// assembled value, and reports a finished value on its last CRC byte.
// ----------------------------------------------------------------------------
module crc8wf_rx (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              start_req,
	input  wire logic [1:0]        value_words,
	output crc8wf_pkg::rx_res_t    res
);

	logic [1:0]  pos_q;
	logic        word_q;
	logic [7:0]  crc_q;
	logic [31:0] acc_q;
	logic        err_q;

	logic [1:0]  pos_e;
	logic        word_e;
	logic [7:0]  crc_e;
	logic [31:0] acc_e;
	logic        err_e;

	logic [1:0]  pos_n;
	logic        word_n;
	logic [7:0]  crc_n;
	logic [31:0] acc_n;
	logic        err_n;
	logic        two_words;
	logic        err_grp;

	always_comb begin
		pos_e  = start_req ? 2'd0 : pos_q;
		word_e = start_req ? 1'b0 : word_q;
		crc_e  = start_req ? crc8wf_pkg::CRC_INIT : crc_q;
		acc_e  = start_req ? 32'd0 : acc_q;
		err_e  = start_req ? 1'b0 : err_q;
		if (pos_e == 2'd3) begin
			pos_e = 2'd0;
		end
		two_words = value_words[1];
		err_grp   = err_e | (data_byte != crc_e);

		pos_n      = pos_e;
		word_n     = word_e;
		crc_n      = crc_e;
		acc_n      = acc_e;
		err_n      = err_e;
		res.emit   = 1'b0;
		res.value  = 32'd0;
		res.crc_ok = 1'b0;

		if (pos_e != 2'd2) begin
			crc_n = crc8wf_pkg::crc_feed(crc_e, data_byte);
			acc_n = {acc_e[23:0], data_byte};
			pos_n = pos_e + 2'd1;
		end else begin
			crc_n = crc8wf_pkg::CRC_INIT;
			pos_n = 2'd0;
			if (!two_words || word_e) begin
				res.emit   = 1'b1;
				res.value  = err_grp ? 32'd0 : acc_e;
				if (!two_words) begin
					res.value[31:16] = 16'd0;
				end
				res.crc_ok = ~err_grp;
				word_n     = 1'b0;
				acc_n      = 32'd0;
				err_n      = 1'b0;
			end else begin
				word_n = 1'b1;
				err_n  = err_grp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			word_q <= 1'b0;
			crc_q  <= crc8wf_pkg::CRC_INIT;
			acc_q  <= 32'd0;
			err_q  <= 1'b0;
		end else if (fire) begin
			pos_q  <= pos_n;
			word_q <= word_n;
			crc_q  <= crc_n;
			acc_q  <= acc_n;
			err_q  <= err_n;
		end
	end

endmodule
`default_nettype wire

>>> sv/crc8wf_tx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8wf_tx
// Transmit sequencer: steps through the bytes of one command frame, one byte
// per step, and builds the argument CRC one byte update at a time.
// ----------------------------------------------------------------------------
module crc8wf_tx (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [15:0]       command,
	input  wire logic [15:0]       argument,
	input  wire logic              has_argument,
	output crc8wf_pkg::tx_res_t    res
);

	crc8wf_pkg::beat_t beat_q;
	crc8wf_pkg::beat_t beat_n;
	logic [7:0]        crc_q;
	logic [7:0]        crc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= crc8wf_pkg::BEAT_CMD_HI;
		end else if (step) begin
			beat_q <= beat_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			crc_q <= crc_n;
		end
	end

	always_comb begin
		beat_n      = crc8wf_pkg::BEAT_CMD_HI;
		crc_n       = crc_q;
		res.tx_byte = 8'd0;
		res.tx_last = 1'b0;
		unique case (beat_q)
			crc8wf_pkg::BEAT_CMD_HI: begin
				res.tx_byte = command[15:8];
				beat_n      = crc8wf_pkg::BEAT_CMD_LO;
			end
			crc8wf_pkg::BEAT_CMD_LO: begin
				res.tx_byte = command[7:0];
				res.tx_last = ~has_argument;
				beat_n      = has_argument ? crc8wf_pkg::BEAT_ARG_HI : crc8wf_pkg::BEAT_CMD_HI;
			end
			crc8wf_pkg::BEAT_ARG_HI: begin
				res.tx_byte = argument[15:8];
				crc_n       = crc8wf_pkg::crc_feed(crc8wf_pkg::CRC_INIT, argument[15:8]);
				beat_n      = crc8wf_pkg::BEAT_ARG_LO;
			end
			crc8wf_pkg::BEAT_ARG_LO: begin
				res.tx_byte = argument[7:0];
				crc_n       = crc8wf_pkg::crc_feed(crc_q, argument[7:0]);
				beat_n      = crc8wf_pkg::BEAT_CRC;
			end
			crc8wf_pkg::BEAT_CRC: begin
				res.tx_byte = crc_q;
				res.tx_last = 1'b1;
				beat_n      = crc8wf_pkg::BEAT_CMD_HI;
			end
			default: begin
				beat_n = crc8wf_pkg::BEAT_CMD_HI;
			end
		endcase
		res.done = step & res.tx_last;
	end

endmodule
`default_nettype wire

>>> sv/crc8_word_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted request is registered in the input stage, then in the output register.
// Received bytes: one request per cycle unless the single result register is stalled.
// Command frames: 2 or 5 bytes, sent one per cycle by the sequencer unless stalled.
// Reset restores all framing state but the TX CRC, and sets value_words to 2 at once.
// ----------------------------------------------------------------------------
// crc8_word_framer
// CRC-8 word framing for a sensor byte link: checks and assembles received
// words into values, and builds command frames with an argument CRC.
// ----------------------------------------------------------------------------
module crc8_word_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output wire logic        in_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_req,
	input  wire logic [15:0] command,
	input  wire logic [15:0] argument,
	input  wire logic        has_argument,
	output wire logic        out_valid,
	input  wire logic        out_stall,
	output wire logic        kind,
	output wire logic [7:0]  tx_byte,
	output wire logic        tx_last,
	output wire logic [31:0] value,
	output wire logic        crc_ok
);

	logic [1:0]  value_words_q;

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  data_byte_s1;
	logic        start_req_s1;
	logic [15:0] command_s1;
	logic [15:0] argument_s1;
	logic        has_argument_s1;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_byte_q;
	logic        tx_last_q;
	logic [31:0] value_q;
	logic        crc_ok_q;

	logic        out_free;
	logic        rx_fire;
	logic        tx_step;
	logic        done_s1;
	logic        accept;

	crc8wf_pkg::rx_res_t rx_res;
	crc8wf_pkg::tx_res_t tx_res;

	assign cfg_ready = 1'b1;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign rx_fire   = valid_s1 & (mode_s1 == crc8wf_pkg::MODE_RX) & out_free;
	assign tx_step   = valid_s1 & (mode_s1 == crc8wf_pkg::MODE_TX) & out_free;
	assign done_s1   = rx_fire | tx_res.done;
	assign in_stall  = valid_s1 & ~done_s1;
	assign accept    = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_words_q <= crc8wf_pkg::VALUE_WORDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			value_words_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1         <= mode;
			data_byte_s1    <= data_byte;
			start_req_s1    <= start_req;
			command_s1      <= command;
			argument_s1     <= argument;
			has_argument_s1 <= has_argument;
		end
	end

	crc8wf_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (rx_fire),
		.data_byte   (data_byte_s1),
		.start_req   (start_req_s1),
		.value_words (value_words_q),
		.res         (rx_res)
	);

	crc8wf_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (tx_step),
		.command      (command_s1),
		.argument     (argument_s1),
		.has_argument (has_argument_s1),
		.res          (tx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (rx_fire & rx_res.emit) | tx_step;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (tx_step) begin
				kind_q    <= crc8wf_pkg::KIND_TX;
				tx_byte_q <= tx_res.tx_byte;
				tx_last_q <= tx_res.tx_last;
				value_q   <= 32'd0;
				crc_ok_q  <= 1'b0;
			end else begin
				kind_q    <= crc8wf_pkg::KIND_VALUE;
				tx_byte_q <= 8'd0;
				tx_last_q <= 1'b0;
				value_q   <= rx_res.value;
				crc_ok_q  <= rx_res.crc_ok;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign tx_byte   = tx_byte_q;
	assign tx_last   = tx_last_q;
	assign value     = value_q;
	assign crc_ok    = crc_ok_q;

endmodule
`default_nettype wire
